/* rtl/core/tsop_pkg.sv */
`default_nettype none

package tsop_pkg;

  // One option-list byte and its end-of-list mark.
  typedef struct packed {
    logic [7:0] opt_byte;
    logic       last_byte;
  } tsop_in_t;

  // Summary of one option list.
  typedef struct packed {
    logic [15:0] mss;
    logic        mss_seen;
    logic [7:0]  wscale_shift;
    logic        wscale_seen;
    logic [1:0]  status;
  } tsop_out_t;

  // Parser phases
  localparam logic [1:0] PH_KIND = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  // Option kinds
  localparam logic [7:0] KIND_EOL    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  localparam logic [7:0] KIND_WSCALE = 8'd3;

  // Smallest legal length byte (kind + length)
  localparam logic [7:0] MIN_OPT_LEN = 8'd2;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_TRUNC  = 2'd1;
  localparam logic [1:0] ST_BADLEN = 2'd2;

endpackage

`default_nettype wire

/* rtl/core/tcp_syn_option_parser_unit.sv */
`default_nettype none

// TCP SYN option parser. Option bytes enter one per beat on the opt channel,
// the final byte of a list marked by last_byte. Kinds 0 and 1 are single-byte
// options; every other kind is skipped by its length byte. A kind 2 option
// captures a big-endian MSS and a kind 3 option a window-scale shift; a later
// copy overrides an earlier one. The byte marked last yields one beat on the
// res channel with both values (0 when absent), their found flags and a
// status: 0 ok, 1 an option was cut off by the end of the list, 2 a length
// byte below 2 (parsing stops there, and the rest of the list is ignored).
// After each list the parser is back in its reset state. Throughput is one
// byte per clock; an accepted last byte passes the input register and then
// the result register before its result beat appears. The input register
// only holds back when it carries a last byte and the result register is
// still full and stalled; plain option bytes never wait on the res side.

module tcp_syn_option_parser_unit
  import tsop_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  // option byte channel
  input  wire logic      opt_valid,
  output logic           opt_stall,
  input  wire tsop_in_t  opt,
  // result channel
  output logic           res_valid,
  input  wire logic      res_stall,
  output tsop_out_t      res
);

  // input register
  logic       in_valid;
  tsop_in_t   in_beat;

  // parser state
  logic [1:0]  phase;
  logic [7:0]  cur_kind;
  logic [7:0]  bytes_left;
  logic [1:0]  body_offset;   // saturates at 2: only offsets 0 and 1 matter
  logic [15:0] mss_value;
  logic [7:0]  scale_value;
  logic [7:0]  mss_high;
  logic [1:0]  found;         // bit 0 MSS, bit 1 window scale
  logic [1:0]  err;

  logic [1:0]  phase_next;
  logic [7:0]  cur_kind_next;
  logic [7:0]  bytes_left_next;
  logic [1:0]  body_offset_next;
  logic [15:0] mss_value_next;
  logic [7:0]  scale_value_next;
  logic [7:0]  mss_high_next;
  logic [1:0]  found_next;
  logic [1:0]  err_next;

  logic        fire;          // input register consumed this cycle
  logic        opt_take;
  logic [1:0]  status;
  tsop_out_t   res_next;

  // A last byte may only leave the input register when the result register
  // is free or draining this cycle.
  assign fire      = in_valid && (!in_beat.last_byte || !res_valid || !res_stall);
  assign opt_stall = in_valid && !fire;
  assign opt_take  = opt_valid && !opt_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (opt_take) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (opt_take) begin
      in_beat <= opt;
    end
  end

  // Byte-level parse step
  always_comb begin
    phase_next       = phase;
    cur_kind_next    = cur_kind;
    bytes_left_next  = bytes_left;
    body_offset_next = body_offset;
    mss_value_next   = mss_value;
    scale_value_next = scale_value;
    mss_high_next    = mss_high;
    found_next       = found;
    err_next         = err;

    case (phase)
      PH_KIND: begin
        if (!(in_beat.opt_byte inside {KIND_EOL, KIND_NOP})) begin
          cur_kind_next = in_beat.opt_byte;
          phase_next    = PH_LEN;
        end
      end
      PH_LEN: begin
        if (in_beat.opt_byte < MIN_OPT_LEN) begin
          err_next   = ST_BADLEN;
          phase_next = PH_STOP;
        end else begin
          bytes_left_next  = in_beat.opt_byte - MIN_OPT_LEN;
          body_offset_next = 2'd0;
          phase_next       = (in_beat.opt_byte == MIN_OPT_LEN) ? PH_KIND : PH_BODY;
        end
      end
      PH_BODY: begin
        if (cur_kind == KIND_MSS) begin
          if (body_offset == 2'd0) begin
            mss_high_next = in_beat.opt_byte;
          end else if (body_offset == 2'd1) begin
            mss_value_next = {mss_high, in_beat.opt_byte};
            found_next[0]  = 1'b1;
          end
        end else if (cur_kind == KIND_WSCALE && body_offset == 2'd0) begin
          scale_value_next = in_beat.opt_byte;
          found_next[1]    = 1'b1;
        end
        body_offset_next = (body_offset == 2'd2) ? 2'd2 : body_offset + 2'd1;
        bytes_left_next  = bytes_left - 8'd1;
        if (bytes_left == 8'd1) begin
          phase_next = PH_KIND;
        end
      end
      default: begin
        // stopped after a bad length: ignore bytes until end of list
      end
    endcase

    if (err_next != ST_OK) begin
      status = err_next;
    end else if (phase_next == PH_LEN || phase_next == PH_BODY) begin
      status = ST_TRUNC;
    end else begin
      status = ST_OK;
    end

    res_next.mss          = found_next[0] ? mss_value_next : 16'd0;
    res_next.mss_seen     = found_next[0];
    res_next.wscale_shift = found_next[1] ? scale_value_next : 8'd0;
    res_next.wscale_seen  = found_next[1];
    res_next.status       = status;
  end

  // Parser state; a last byte returns it to reset for the next list.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_KIND;
      cur_kind    <= 8'd0;
      bytes_left  <= 8'd0;
      body_offset <= 2'd0;
      mss_value   <= 16'd0;
      scale_value <= 8'd0;
      mss_high    <= 8'd0;
      found       <= 2'd0;
      err         <= ST_OK;
    end else if (fire) begin
      if (in_beat.last_byte) begin
        phase       <= PH_KIND;
        cur_kind    <= 8'd0;
        bytes_left  <= 8'd0;
        body_offset <= 2'd0;
        mss_value   <= 16'd0;
        scale_value <= 8'd0;
        mss_high    <= 8'd0;
        found       <= 2'd0;
        err         <= ST_OK;
      end else begin
        phase       <= phase_next;
        cur_kind    <= cur_kind_next;
        bytes_left  <= bytes_left_next;
        body_offset <= body_offset_next;
        mss_value   <= mss_value_next;
        scale_value <= scale_value_next;
        mss_high    <= mss_high_next;
        found       <= found_next;
        err         <= err_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && in_beat.last_byte) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_beat.last_byte) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

/* sim/tcp_syn_option_parser_unit_tb.sv */
`timescale 1ns / 100ps

module tcp_syn_option_parser_unit_tb
  import tsop_pkg::*;
();

  // Run limit in clocks.
  localparam int CYCLE_LIMIT   = 200000;
  // Random stimulus size, in option bytes.
  localparam int RANDOM_BEATS  = 950;
  // Idle / stall odds, percent per cycle.
  localparam int IDLE_PCT      = 17;
  // Window (in clocks) where neither side idles, to run at full line rate.
  localparam int STEADY_FROM   = 300;
  localparam int STEADY_TO     = 650;
  // Clocks allowed for stray results after the last expected one.
  localparam int DRAIN_CYCLES  = 12;

  // One stimulus beat: the byte, whether its summary is typed in by hand,
  // and that hand-typed summary (ignored for rows checked by the predictor).
  typedef struct packed {
    tsop_in_t  beat;
    logic      typed;
    tsop_out_t want;
  } stim_row_t;

  localparam int DIR_ROWS = 24;

  // Directed lists. Typed rows carry a summary that can be read straight off
  // the option bytes; the rest are left to the predictor.
  localparam stim_row_t [0:DIR_ROWS-1] DIRECTED_LISTS = {
    // end-of-list byte alone
    {8'h00, 1'b1, 1'b1, 16'h0000, 1'b0, 8'h00, 1'b0, ST_OK},
    // NOP alone
    {8'h01, 1'b1, 1'b1, 16'h0000, 1'b0, 8'h00, 1'b0, ST_OK},
    // MSS with all-ones value
    {8'h02, 1'b0, 1'b0, 28'h0},
    {8'h04, 1'b0, 1'b0, 28'h0},
    {8'hFF, 1'b0, 1'b0, 28'h0},
    {8'hFF, 1'b1, 1'b1, 16'hFFFF, 1'b1, 8'h00, 1'b0, ST_OK},
    // window scale, all-ones shift
    {8'h03, 1'b0, 1'b0, 28'h0},
    {8'h03, 1'b0, 1'b0, 28'h0},
    {8'hFF, 1'b1, 1'b1, 16'h0000, 1'b0, 8'hFF, 1'b1, ST_OK},
    // length byte of 1, then a trailing byte that must be ignored
    {8'h05, 1'b0, 1'b0, 28'h0},
    {8'h01, 1'b0, 1'b0, 28'h0},
    {8'h02, 1'b1, 1'b1, 16'h0000, 1'b0, 8'h00, 1'b0, ST_BADLEN},
    // length byte of 0 on the last byte
    {8'hFE, 1'b0, 1'b0, 28'h0},
    {8'h00, 1'b1, 1'b1, 16'h0000, 1'b0, 8'h00, 1'b0, ST_BADLEN},
    // MSS cut off inside its body
    {8'h02, 1'b0, 1'b0, 28'h0},
    {8'h04, 1'b0, 1'b0, 28'h0},
    {8'h00, 1'b1, 1'b1, 16'h0000, 1'b0, 8'h00, 1'b0, ST_TRUNC},
    // list ends while waiting for a length byte
    {8'h08, 1'b1, 1'b1, 16'h0000, 1'b0, 8'h00, 1'b0, ST_TRUNC},
    // short MSS (one body byte), then NOP
    {8'h02, 1'b0, 1'b0, 28'h0},
    {8'h03, 1'b0, 1'b0, 28'h0},
    {8'hAA, 1'b0, 1'b0, 28'h0},
    {8'h01, 1'b1, 1'b0, 28'h0},
    // window scale with no body byte
    {8'h03, 1'b0, 1'b0, 28'h0},
    {8'h02, 1'b1, 1'b0, 28'h0}
  };

  logic      clk;
  logic      rst;
  logic      opt_valid;
  logic      opt_stall;
  tsop_in_t  opt;
  logic      res_valid;
  logic      res_stall;
  tsop_out_t res;

  stim_row_t stim_q[$];
  tsop_out_t summary_q[$];   // summaries still owed by the DUT
  int        opt_pos;        // next stimulus row to drive
  int        opt_taken;      // option beats accepted so far
  int        cycles;
  int        errors;
  logic      steady;         // no idling on either side

  // Predictor state: one option list in flight.
  logic [1:0]  scan_phase;
  logic [7:0]  scan_kind;
  logic [7:0]  scan_left;
  logic [7:0]  scan_offset;
  logic [15:0] scan_mss;
  logic [7:0]  scan_mss_hi;
  logic [7:0]  scan_wscale;
  logic [1:0]  scan_found;   // bit 0 MSS, bit 1 window scale
  logic [1:0]  scan_err;

  tcp_syn_option_parser_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .opt_valid (opt_valid),
    .opt_stall (opt_stall),
    .opt       (opt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic clear_scan;
    scan_phase  = PH_KIND;
    scan_kind   = '0;
    scan_left   = '0;
    scan_offset = '0;
    scan_mss    = '0;
    scan_mss_hi = '0;
    scan_wscale = '0;
    scan_found  = '0;
    scan_err    = ST_OK;
  endtask

  // Advance the option scanner by one byte; on the last byte of a list,
  // hand back the list summary and start over.
  task automatic scan_option_byte(input tsop_in_t beat, output logic done,
                                  output tsop_out_t sum);
    logic [7:0] b;
    logic [1:0] st;
    b = beat.opt_byte;
    case (scan_phase)
      PH_KIND: begin
        // EOL and NOP are single bytes, anything else has a length byte
        if (b != KIND_EOL && b != KIND_NOP) begin
          scan_kind  = b;
          scan_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b < MIN_OPT_LEN) begin
          scan_err   = ST_BADLEN;
          scan_phase = PH_STOP;
        end else begin
          scan_left   = b - MIN_OPT_LEN;
          scan_offset = '0;
          scan_phase  = (scan_left == 8'd0) ? PH_KIND : PH_BODY;
        end
      end
      PH_BODY: begin
        if (scan_kind == KIND_MSS) begin
          if (scan_offset == 8'd0) begin
            scan_mss_hi = b;
          end else if (scan_offset == 8'd1) begin
            scan_mss      = {scan_mss_hi, b};
            scan_found[0] = 1'b1;
          end
        end else if (scan_kind == KIND_WSCALE && scan_offset == 8'd0) begin
          scan_wscale   = b;
          scan_found[1] = 1'b1;
        end
        scan_offset = scan_offset + 8'd1;
        scan_left   = scan_left - 8'd1;
        if (scan_left == 8'd0) scan_phase = PH_KIND;
      end
      default: ;  // stopped on a bad length: ignore until end of list
    endcase

    done = beat.last_byte;
    sum  = '0;
    if (done) begin
      st = scan_err;
      if (st == ST_OK && (scan_phase == PH_LEN || scan_phase == PH_BODY)) st = ST_TRUNC;
      sum.mss          = scan_found[0] ? scan_mss : 16'd0;
      sum.mss_seen     = scan_found[0];
      sum.wscale_shift = scan_found[1] ? scan_wscale : 8'd0;
      sum.wscale_seen  = scan_found[1];
      sum.status       = st;
      clear_scan();
    end
  endtask

  // Build one random option list and queue its bytes. Mostly well-formed
  // options with random content; some short/odd lengths, bad lengths,
  // random noise and lists cut off mid-option.
  task automatic add_random_list;
    logic [7:0] lst[$];
    int         n_opts;
    int         sel;
    int         len;
    stim_row_t  row;
    n_opts = $urandom_range(0, 5);
    for (int i = 0; i < n_opts; i++) begin
      sel = $urandom_range(99);
      if (sel < 14) begin
        lst.push_back(KIND_NOP);
      end else if (sel < 19) begin
        lst.push_back(KIND_EOL);
      end else if (sel < 43) begin
        lst.push_back(KIND_MSS);
        lst.push_back(8'd4);
        lst.push_back(8'($urandom));
        lst.push_back(8'($urandom));
      end else if (sel < 62) begin
        lst.push_back(KIND_WSCALE);
        lst.push_back(8'd3);
        lst.push_back(8'($urandom));
      end else if (sel < 78) begin
        // some other option kind, skipped by its length
        lst.push_back(8'($urandom_range(4, 255)));
        len = $urandom_range(2, 9);
        lst.push_back(8'(len));
        for (int k = 2; k < len; k++) lst.push_back(8'($urandom));
      end else if (sel < 88) begin
        // MSS or window scale with an unusual length
        lst.push_back($urandom_range(1) ? KIND_MSS : KIND_WSCALE);
        len = $urandom_range(2, 7);
        lst.push_back(8'(len));
        for (int k = 2; k < len; k++) lst.push_back(8'($urandom));
      end else if (sel < 93) begin
        // length byte below the minimum
        lst.push_back(8'($urandom_range(2, 255)));
        lst.push_back(8'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) lst.push_back(8'($urandom));
      end
    end
    if (lst.size() == 0) lst.push_back(8'($urandom));
    // cut some lists short so the last byte can land inside an option
    if (lst.size() > 1 && $urandom_range(99) < 10) begin
      len = $urandom_range(1, lst.size() - 1);
      while (lst.size() > len) void'(lst.pop_back());
    end
    foreach (lst[i]) begin
      row                = '0;
      row.beat.opt_byte  = lst[i];
      row.beat.last_byte = (i == lst.size() - 1);
      stim_q.push_back(row);
    end
  endtask

  task automatic check_summary(input tsop_out_t got);
    tsop_out_t exp_sum;
    if (summary_q.size() == 0) begin
      $display("%0t: unexpected result beat %h", $time, got);
      errors++;
    end else begin
      exp_sum = summary_q.pop_front();
      if (got.mss !== exp_sum.mss) begin
        $display("%0t: mss exp %h got %h", $time, exp_sum.mss, got.mss);
        errors++;
      end
      if (got.mss_seen !== exp_sum.mss_seen) begin
        $display("%0t: mss_seen exp %b got %b", $time, exp_sum.mss_seen, got.mss_seen);
        errors++;
      end
      if (got.wscale_shift !== exp_sum.wscale_shift) begin
        $display("%0t: wscale_shift exp %h got %h", $time, exp_sum.wscale_shift,
                 got.wscale_shift);
        errors++;
      end
      if (got.wscale_seen !== exp_sum.wscale_seen) begin
        $display("%0t: wscale_seen exp %b got %b", $time, exp_sum.wscale_seen,
                 got.wscale_seen);
        errors++;
      end
      if (got.status !== exp_sum.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp_sum.status, got.status);
        errors++;
      end
    end
  endtask

  // Cycle counter, steady window and watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    steady <= (cycles >= STEADY_FROM && cycles < STEADY_TO);
    if (cycles >= CYCLE_LIMIT) begin
      $display("** tcp_syn_option_parser_unit: FAILED **");
      $finish;
    end
  end

  // Byte source: a held beat stays put while stalled; otherwise pick the next
  // row or idle.
  always @(posedge clk) begin
    if (rst) begin
      opt_valid <= 1'b0;
    end else if (!opt_valid || !opt_stall) begin
      if (opt_pos < stim_q.size() && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        opt_valid <= 1'b1;
        opt       <= stim_q[opt_pos].beat;
        opt_pos   <= opt_pos + 1;
      end else begin
        opt_valid <= 1'b0;
      end
    end
  end

  // Result sink stalls at random outside the steady window.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Monitor: predict on each accepted byte, check each accepted result.
  always @(posedge clk) begin
    logic      done;
    tsop_out_t sum;
    if (!rst) begin
      if (opt_valid && !opt_stall) begin
        scan_option_byte(opt, done, sum);
        if (done) begin
          // hand-typed rows are checked against their own summary
          if (stim_q[opt_taken].typed) sum = stim_q[opt_taken].want;
          summary_q.push_back(sum);
        end
        opt_taken <= opt_taken + 1;
      end
      if (res_valid && !res_stall) check_summary(res);
    end
  end

  initial begin
    rst       = 1'b1;
    opt_valid = 1'b0;
    opt       = '0;
    res_stall = 1'b0;
    opt_pos   = 0;
    opt_taken = 0;
    cycles    = 0;
    errors    = 0;
    steady    = 1'b0;
    clear_scan();

    for (int i = 0; i < DIR_ROWS; i++) stim_q.push_back(DIRECTED_LISTS[i]);
    while (stim_q.size() < DIR_ROWS + RANDOM_BEATS) add_random_list();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (opt_taken < stim_q.size()) @(posedge clk);
    while (summary_q.size() != 0) @(posedge clk);
    // any stray result beat shows up here as unexpected
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("** tcp_syn_option_parser_unit: PASSED **");
    end else begin
      $display("** tcp_syn_option_parser_unit: FAILED **");
    end
    $finish;
  end

endmodule
